/* rtl/dseq_pkg.sv */
// ----------------------------------------------------------------------------
// dseq_pkg: shared types and constants for the delay-sorted event queue
// Entry layout, cell commands and sizing constants used by the cell chain
// and its controller.
// ----------------------------------------------------------------------------
package dseq_pkg;

  // Default number of queue slots.
  localparam int DEPTH_DEF = 16;

  // Largest number of events that a single tick may fire.
  localparam int MAX_RESULTS = 16;

  // Field widths.
  localparam int DLY_W = 16;
  localparam int TGT_W = 16;
  localparam int PAY_W = 16;

  // Width of the per-tick fired-event counter.
  localparam int FCNT_W = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;

  // Operation codes carried on in_tuser.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  // One queue entry.
  typedef struct packed {
    logic             vld;
    logic [DLY_W-1:0] dly;
    logic [TGT_W-1:0] tgt;
    logic [PAY_W-1:0] pay;
  } entry_t;

  // Command broadcast to every cell of the chain.
  typedef enum logic [1:0] {
    CMD_HOLD = 2'd0,
    CMD_INS  = 2'd1,
    CMD_POP  = 2'd2,
    CMD_DEC  = 2'd3
  } cell_cmd_t;

endpackage

/* rtl/dseq_cell.sv */
// ----------------------------------------------------------------------------
// dseq_cell: one slot of the sorted event chain
// Holds one entry. On insert it either keeps its entry, takes the new event
// or takes its lower neighbor's entry; on pop it takes its upper neighbor's
// entry; on decrement it lowers its delay, stopping at zero.
// ----------------------------------------------------------------------------
module dseq_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  dseq_pkg::cell_cmd_t cmd_i,
  input  dseq_pkg::entry_t   new_i,    // event being inserted
  input  dseq_pkg::entry_t   prev_i,   // entry of the slot one closer to the head
  input  logic               prev_gt_i,// insert position lies at or before prev slot
  input  dseq_pkg::entry_t   next_i,   // entry of the slot one further from the head
  output dseq_pkg::entry_t   ent_o,
  output logic               gt_o      // this slot is free or its delay is greater
);
  import dseq_pkg::*;

  entry_t ent_r;
  entry_t ent_nxt;

  // The new event goes in front of any slot that is empty or strictly later.
  assign gt_o  = !ent_r.vld || (ent_r.dly > new_i.dly);
  assign ent_o = ent_r;

  // Next entry for each command.
  always_comb begin
    ent_nxt = ent_r;
    case (cmd_i)
      CMD_INS: begin
        if (prev_gt_i) begin
          ent_nxt = prev_i;
        end else if (gt_o) begin
          ent_nxt     = new_i;
          ent_nxt.vld = 1'b1;
        end
      end
      CMD_POP: begin
        ent_nxt = next_i;
      end
      CMD_DEC: begin
        if (ent_r.dly != '0) begin
          ent_nxt.dly = ent_r.dly - DLY_W'(1);
        end
      end
      default: begin
        ent_nxt = ent_r;
      end
    endcase
  end

  // Entry register; reset leaves the slot empty.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r <= '0;
    end else begin
      ent_r <= ent_nxt;
    end
  end

endmodule

/* rtl/delay_sorted_event_queue_unit.sv */
// ----------------------------------------------------------------------------
// delay_sorted_event_queue_unit: delta-timer event queue
// An insert request (in_tuser low) is stored in delay order behind all
// events of equal or smaller delay; if all DEPTH slots are full it instead
// produces one result with out_tuser (dropped) set. A tick request
// (in_tuser high) first lowers every delay, then fires the expired events
// from the head of the chain at one result per cycle while out_tready does
// not hold off the output register, up to sixteen per tick, the final one
// marked by out_tlast. No new request is taken while a tick is firing.
// ----------------------------------------------------------------------------
module delay_sorted_event_queue_unit #(
  parameter int DEPTH = dseq_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input request channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // [15:0] delay, [31:16] target_id, [47:32] payload
  input  logic        in_tuser,   // [0] operation
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [15:0] fired_target, [31:16] fired_payload
  output logic        out_tuser,  // [0] dropped
  output logic        out_tlast
);
  import dseq_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_FIRE = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  logic [FCNT_W-1:0] fcnt_r, fcnt_nxt;
  logic              out_vld_r, out_vld_nxt;
  entry_t            out_ent_r, out_ent_nxt;
  logic              out_drop_r, out_drop_nxt;
  logic              out_last_r, out_last_nxt;

  cell_cmd_t cmd;
  entry_t    new_ent;
  entry_t    ent_w   [DEPTH];
  logic      gt_w    [DEPTH];

  logic in_acc;
  logic slot_free;
  logic full;
  logic head_exp;
  logic next_exp;
  logic fire_last;

  // Unpack the request.
  always_comb begin
    new_ent.vld = 1'b1;
    new_ent.dly = in_tdata[15:0];
    new_ent.tgt = in_tdata[31:16];
    new_ent.pay = in_tdata[47:32];
  end

  // Chain of cells; the head is slot 0.
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    entry_t prev_e;
    entry_t next_e;
    logic   prev_gt;

    if (g == 0) begin : g_head
      assign prev_e  = '0;
      assign prev_gt = 1'b0;
    end else begin : g_body
      assign prev_e  = ent_w[g-1];
      assign prev_gt = gt_w[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign next_e = '0;
    end else begin : g_mid
      assign next_e = ent_w[g+1];
    end

    dseq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd_i     (cmd),
      .new_i     (new_ent),
      .prev_i    (prev_e),
      .prev_gt_i (prev_gt),
      .next_i    (next_e),
      .ent_o     (ent_w[g]),
      .gt_o      (gt_w[g])
    );
  end

  // Status taken from the head, second slot and tail of the chain.
  assign full      = ent_w[DEPTH-1].vld;
  assign head_exp  = ent_w[0].vld && (ent_w[0].dly == '0);
  assign next_exp  = ent_w[1].vld && (ent_w[1].dly == '0);
  assign fire_last = !next_exp || (fcnt_r == FCNT_W'(MAX_RESULTS - 1));

  assign slot_free = !out_vld_r || out_tready;
  assign in_tready = (state_r == ST_IDLE) && slot_free;
  assign in_acc    = in_tvalid && in_tready;

  // Sequencer: decides the chain command and loads the output register.
  always_comb begin
    state_nxt    = state_r;
    fcnt_nxt     = fcnt_r;
    cmd          = CMD_HOLD;
    out_vld_nxt  = out_vld_r && !out_tready;
    out_ent_nxt  = out_ent_r;
    out_drop_nxt = out_drop_r;
    out_last_nxt = out_last_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_tuser == OP_TICK) begin
            cmd       = CMD_DEC;
            fcnt_nxt  = '0;
            state_nxt = ST_FIRE;
          end else if (full) begin
            // Refused insert reports the event back.
            out_vld_nxt  = 1'b1;
            out_ent_nxt  = new_ent;
            out_drop_nxt = 1'b1;
            out_last_nxt = 1'b1;
          end else begin
            cmd = CMD_INS;
          end
        end
      end
      ST_FIRE: begin
        if (!head_exp) begin
          state_nxt = ST_IDLE;
        end else if (slot_free) begin
          cmd          = CMD_POP;
          out_vld_nxt  = 1'b1;
          out_ent_nxt  = ent_w[0];
          out_drop_nxt = 1'b0;
          out_last_nxt = fire_last;
          fcnt_nxt     = fcnt_r + FCNT_W'(1);
          if (fire_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      fcnt_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      fcnt_r    <= fcnt_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    out_ent_r  <= out_ent_nxt;
    out_drop_r <= out_drop_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_ent_r.pay, out_ent_r.tgt};
  assign out_tuser  = out_drop_r;
  assign out_tlast  = out_last_r;

endmodule

/* rtl/dseq_checker.sv */
// ----------------------------------------------------------------------------
// dseq_checker: port-level checks for the delay-sorted event queue
// Watches the request and result channels of the top level.
// ----------------------------------------------------------------------------
module dseq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  // A refused insert is always the only, and so the last, result of its request.
  a_drop_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("dropped result not marked last");

  // A tick request blocks the input for at least the following cycle.
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> !in_tready)
    else $error("request taken right after a tick");

  // A stalled result holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
      $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

endmodule

bind delay_sorted_event_queue_unit dseq_checker u_dseq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
